// File: sv/qls_pkg.sv
// ----------------------------------------------------------------------------
// qls_pkg
// Shared types and constants for the tabular q-learning step unit.
// ----------------------------------------------------------------------------
package qls_pkg;

  localparam int MaxStates = 8;
  localparam int SW        = $clog2(MaxStates);
  localparam int AW        = 2 * SW;
  localparam int Depth     = MaxStates * MaxStates;
  localparam int CntW      = $clog2(MaxStates + 1);
  localparam int FracBits  = 8;
  localparam int QW        = 12 + FracBits;
  localparam int RW        = 10;
  localparam int GainW     = 8;
  localparam int ProdW     = GainW + QW;
  localparam int RndW      = 16;
  localparam int FieldW    = 3;
  localparam int UsedW     = 4;

  localparam logic [QW-1:0] QMax = {QW{1'b1}};

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRAIN = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_PLACE = 2'd3
  } kind_e;

  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_GOAL = 2'd1;
  localparam logic [1:0] CFG_USED = 2'd2;

  typedef struct packed {
    kind_e                kind;
    logic [FieldW-1:0]    state_index;
    logic [FieldW-1:0]    action_index;
    logic signed [RW-1:0] reward;
    logic [RndW-1:0]      pick_random;
    logic [RndW-1:0]      restart_random;
  } item_t;

  typedef struct packed {
    logic [GainW-1:0]  discount_gain;
    logic [FieldW-1:0] goal_state;
    logic [UsedW-1:0]  states_in_use;
  } cfg_t;

  typedef struct packed {
    logic              no_move_error;
    logic [QW-1:0]     best_q;
    logic [FieldW-1:0] top_action;
    logic              episode_done;
    logic [QW-1:0]     updated_q;
    logic [FieldW-1:0] taken_action;
  } res_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qent_t;

endpackage

// File: sv/tabular_q_learning_step_unit.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit
// Tabular q-learning on a reward graph of up to eight states.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel (kind in tuser) and queue in a
// two-entry buffer, so the sender is held off only when that buffer is full.
// Each request gives exactly one result on m_axis; write and place requests
// give an all-zero result.
// Register writes come on the cfg channel, which is always ready; they must
// be made only while no request is in flight; the block itself does not enforce this.
// A query scans one q row at one entry a cycle; a training step scans
// the reward row, runs a bit-serial remainder to pick a move, scans the
// target row, then multiplies and adds, and runs a second remainder
// for the restart state when the goal is reached. Scans go through
// the single table read port.
// Reset puts the agent in state 1, clears the q table and fills the reward
// table with -1 through per-entry valid bits, so requests are taken at once.
// While a result waits for m_axis_tready, later requests still queue but
// are not executed.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // state_index[2:0] action_index[5:3] reward[15:6] pick_random[31:16]
  // restart_random[47:32]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // taken_action[2:0] updated_q[22:3] episode_done[23] top_action[26:24]
  // best_q[46:27] no_move_error[47]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import qls_pkg::*;

  cfg_t  cfg;
  qent_t head;
  logic  pop;
  res_t  res;

  qls_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_o         (cfg),
    .head_o        (head),
    .pop_i         (pop)
  );

  qls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {res.no_move_error, res.best_q, res.top_action,
                         res.episode_done, res.updated_q, res.taken_action};

endmodule

// File: sv/qls_front.sv
// ----------------------------------------------------------------------------
// qls_front
// Takes requests and register writes, decodes the kind and queues requests.
// ----------------------------------------------------------------------------
module qls_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  output qls_pkg::cfg_t          cfg_o,
  output qls_pkg::qent_t         head_o,
  input  logic                   pop_i
);
  import qls_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  cfg_t        cfg_q, cfg_d;
  item_t       in_item;
  logic        push, pop;

  always_comb begin
    in_item.kind           = kind_e'(s_axis_tuser);
    in_item.state_index    = s_axis_tdata[2:0];
    in_item.action_index   = s_axis_tdata[5:3];
    in_item.reward         = s_axis_tdata[15:6];
    in_item.pick_random    = s_axis_tdata[31:16];
    in_item.restart_random = s_axis_tdata[47:32];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (cnt_q != 2'd0);
  assign head_o.valid  = (cnt_q != 2'd0);
  assign head_o.item   = mem_q[rp_q];
  assign cfg_ready_o   = 1'b1;
  assign cfg_o         = cfg_q;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GAIN: cfg_d.discount_gain = cfg_data_i;
        CFG_GOAL: cfg_d.goal_state    = cfg_data_i[FieldW-1:0];
        CFG_USED: cfg_d.states_in_use = cfg_data_i[UsedW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      cfg_q <= '{discount_gain: 8'd205, goal_state: 3'd5, states_in_use: 4'd6};
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item;
    end
  end

endmodule

// File: sv/qls_mod.sv
// ----------------------------------------------------------------------------
// qls_mod
// Bit-serial remainder of a 16-bit value by a small divisor.
// ----------------------------------------------------------------------------
module qls_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qls_pkg::RndW-1:0]    num_i,
  input  logic [qls_pkg::CntW-1:0]    den_i,
  output logic                        done_o,
  output logic [qls_pkg::CntW-1:0]    rem_o
);
  import qls_pkg::*;

  localparam int StepW = $clog2(RndW + 1);

  logic [RndW-1:0]  num_q, num_d;
  logic [CntW-1:0]  den_q, den_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW:0]    trial;

  assign trial  = {rem_q, num_q[RndW-1]};
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = num_q << 1;
      rem_d  = (trial >= {1'b0, den_q}) ? CntW'(trial - {1'b0, den_q}) : CntW'(trial);
      step_d = step_q + 1'b1;
      if (step_q == StepW'(RndW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

endmodule

// File: sv/qls_back.sv
// ----------------------------------------------------------------------------
// qls_back
// Executes queued requests against the reward and q tables.
// ----------------------------------------------------------------------------
module qls_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qls_pkg::cfg_t     cfg_i,
  input  qls_pkg::qent_t    head_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output qls_pkg::res_t     res_o
);
  import qls_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RSCAN = 8'b0000_0010,
    S_PMOD  = 8'b0000_0100,
    S_ASCAN = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_RMOD  = 8'b0100_0000,
    S_QSCAN = 8'b1000_0000
  } state_e;

  state_e               st_q, st_d;
  item_t                it_q, it_d;
  logic [SW-1:0]        ag_q, ag_d, row_q, row_d, act_q, act_d;
  logic [CntW-1:0]      cnt_q, cnt_d, acnt_q, acnt_d, used;
  logic [MaxStates-1:0] mask_q, mask_d;
  logic [RW-1:0]        rrow_q [MaxStates];
  logic [RW-1:0]        rrow_d [MaxStates];
  logic [QW-1:0]        mx_q, mx_d;
  logic [ProdW-1:0]     prod_q, prod_d;
  logic                 ovld_q, ovld_d;
  res_t                 res_q, res_d;

  logic [RW-1:0]        rmem [Depth];
  logic [QW-1:0]        qmem [Depth];
  logic [Depth-1:0]     rval_q, qval_q;
  logic                 rd_en, pend_q;
  logic [AW-1:0]        raddr;
  logic [SW-1:0]        pidx_q;
  logic [RW-1:0]        rdat_q;
  logic [QW-1:0]        qdat_q;
  logic                 rv_q, qv_q;
  logic [RW-1:0]        rd_rew;
  logic [QW-1:0]        rd_q;
  logic                 rd_ok;

  logic                 rw_en, qw_en;
  logic [AW-1:0]        rw_addr, qw_addr;
  logic [QW-1:0]        qw_data;

  logic                 mstart, mdone;
  logic [RndW-1:0]      mnum;
  logic [CntW-1:0]      mden, mrem;

  logic [QW:0]          sum;
  logic [QW-1:0]        sat;
  logic                 scan_end, in_range_s;

  function automatic logic [SW-1:0] kth_set(logic [MaxStates-1:0] m, logic [CntW-1:0] k);
    logic [CntW-1:0] seen;
    logic [SW-1:0]   idx;
    seen = '0;
    idx  = '0;
    for (int i = 0; i < MaxStates; i++) begin
      if (m[i]) begin
        if (seen == k) idx = SW'(i);
        seen = seen + 1'b1;
      end
    end
    return idx;
  endfunction

  qls_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .num_i   (mnum),
    .den_i   (mden),
    .done_o  (mdone),
    .rem_o   (mrem)
  );

  assign used = (cfg_i.states_in_use == '0) ? CntW'(1) :
                ({1'b0, cfg_i.states_in_use} > (UsedW+1)'(MaxStates)) ? CntW'(MaxStates) :
                CntW'(cfg_i.states_in_use);

  assign rd_rew   = rv_q ? rdat_q : {RW{1'b1}};
  assign rd_q     = qv_q ? qdat_q : '0;
  assign rd_ok    = !rd_rew[RW-1];
  assign scan_end = (cnt_q == used) && !pend_q;
  assign in_range_s = (32'(head_i.item.state_index) < MaxStates);

  assign prod_d = prod_q;
  assign sum    = {1'b0, QW'(rrow_q[act_q][RW-2:0]) << FracBits}
                + {1'b0, prod_q[ProdW-1:GainW]};
  assign sat    = sum[QW] ? QMax : sum[QW-1:0];

  assign m_axis_tvalid = ovld_q;
  assign res_o         = res_q;

  always_comb begin
    st_d    = st_q;
    it_d    = it_q;
    ag_d    = ag_q;
    row_d   = row_q;
    act_d   = act_q;
    cnt_d   = cnt_q;
    acnt_d  = acnt_q;
    mask_d  = mask_q;
    rrow_d  = rrow_q;
    mx_d    = mx_q;
    ovld_d  = ovld_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    raddr   = {row_q, cnt_q[SW-1:0]};
    rw_en   = 1'b0;
    rw_addr = {it_q.state_index[SW-1:0], it_q.action_index[SW-1:0]};
    qw_en   = 1'b0;
    qw_addr = {ag_q, act_q};
    qw_data = sat;
    mstart  = 1'b0;
    mnum    = it_q.pick_random;
    mden    = acnt_q;

    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    if ((st_q == S_RSCAN || st_q == S_ASCAN || st_q == S_QSCAN) && cnt_q != used) begin
      rd_en = 1'b1;
      cnt_d = cnt_q + 1'b1;
    end

    unique case (st_q)
      S_IDLE: begin
        if (head_i.valid && !ovld_q) begin
          pop_o  = 1'b1;
          it_d   = head_i.item;
          res_d  = '0;
          cnt_d  = '0;
          acnt_d = '0;
          mask_d = '0;
          mx_d   = '0;
          unique case (head_i.item.kind)
            KIND_WRITE: ovld_d = 1'b1;
            KIND_PLACE: begin
              if (in_range_s) ag_d = head_i.item.state_index[SW-1:0];
              ovld_d = 1'b1;
            end
            KIND_QUERY: begin
              if (in_range_s) begin
                row_d   = head_i.item.state_index[SW-1:0];
                st_d    = S_QSCAN;
              end else begin
                ovld_d = 1'b1;
              end
            end
            KIND_TRAIN: begin
              row_d = ag_q;
              st_d  = S_RSCAN;
            end
            default: st_d = S_IDLE;
          endcase
        end
      end
      S_RSCAN: begin
        if (pend_q && rd_ok) begin
          mask_d[pidx_q] = 1'b1;
          rrow_d[pidx_q] = rd_rew;
          acnt_d = acnt_q + 1'b1;
        end
        if (scan_end) begin
          if (acnt_q == '0) begin
            res_d.no_move_error = 1'b1;
            ovld_d = 1'b1;
            st_d   = S_IDLE;
          end else begin
            mstart = 1'b1;
            st_d   = S_PMOD;
          end
        end
      end
      S_PMOD: begin
        if (mdone) begin
          act_d = kth_set(mask_q, mrem);
          row_d = kth_set(mask_q, mrem);
          cnt_d = '0;
          st_d  = S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (pend_q && rd_ok && rd_q > mx_q) mx_d = rd_q;
        if (scan_end) st_d = S_MUL;
      end
      S_MUL: st_d = S_SUM;
      S_SUM: begin
        qw_en = 1'b1;
        res_d.taken_action = FieldW'(act_q);
        res_d.updated_q    = sat;
        if (FieldW'(act_q) == cfg_i.goal_state) begin
          res_d.episode_done = 1'b1;
          mstart = 1'b1;
          mnum   = it_q.restart_random;
          mden   = used;
          st_d   = S_RMOD;
        end else begin
          ag_d   = act_q;
          ovld_d = 1'b1;
          st_d   = S_IDLE;
        end
      end
      S_RMOD: begin
        mden = used;
        if (mdone) begin
          ag_d   = mrem[SW-1:0];
          ovld_d = 1'b1;
          st_d   = S_IDLE;
        end
      end
      S_QSCAN: begin
        if (pend_q && rd_q > res_q.best_q) begin
          res_d.best_q     = rd_q;
          res_d.top_action = FieldW'(pidx_q);
        end
        if (scan_end) begin
          ovld_d = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (st_q == S_IDLE && head_i.valid && !ovld_q && head_i.item.kind == KIND_WRITE
        && (32'(head_i.item.state_index) < MaxStates)
        && (32'(head_i.item.action_index) < MaxStates)) begin
      rw_en   = 1'b1;
      rw_addr = {head_i.item.state_index[SW-1:0], head_i.item.action_index[SW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ag_q   <= SW'(1);
      ovld_q <= 1'b0;
      pend_q <= 1'b0;
      rval_q <= '0;
      qval_q <= '0;
    end else begin
      st_q   <= st_d;
      ag_q   <= ag_d;
      ovld_q <= ovld_d;
      pend_q <= rd_en;
      if (rw_en) rval_q[rw_addr] <= 1'b1;
      if (qw_en) qval_q[qw_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    row_q   <= row_d;
    act_q   <= act_d;
    cnt_q   <= cnt_d;
    acnt_q  <= acnt_d;
    mask_q  <= mask_d;
    rrow_q  <= rrow_d;
    mx_q    <= mx_d;
    prod_q  <= (st_q == S_MUL) ? ProdW'(cfg_i.discount_gain * mx_q) : prod_d;
    res_q   <= res_d;
    pidx_q  <= cnt_q[SW-1:0];
  end

  // table memories with registered read
  always_ff @(posedge clk_i) begin
    if (rw_en) rmem[rw_addr] <= head_i.item.reward;
    if (qw_en) qmem[qw_addr] <= qw_data;
    if (rd_en) begin
      rdat_q <= rmem[raddr];
      qdat_q <= qmem[raddr];
      rv_q   <= rval_q[raddr];
      qv_q   <= qval_q[raddr];
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tabular q-learning step unit.
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and fed to s_axis in random
// bursts; results on m_axis are checked against a behavioural predictor of
// the reward table, the q table and the agent position. Register writes are
// made between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import qls_pkg::*;

  localparam int CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  tabular_q_learning_step_unit dut (.*);

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // predictor state
  logic [7:0]           gain_m;
  logic [2:0]           goal_m;
  logic [3:0]           used_m;
  logic [2:0]           agent_m;
  logic [QW-1:0]        qtab_m [Depth];
  logic signed [RW-1:0] rtab_m [Depth];

  item_t pending_q [$];
  res_t  expected_q [$];
  int    errors = 0;
  int    cycles = 0;
  bit    hold_rx = 1'b0;

  function automatic int used_n();
    if (used_m == 0) return 1;
    if (used_m > MaxStates) return MaxStates;
    return int'(used_m);
  endfunction

  function automatic res_t predict_step(item_t it);
    res_t r;
    int n, cnt, a, s, idx;
    int moves [MaxStates];
    logic [QW-1:0] mx;
    logic [63:0] sum;
    r = '0;
    n = used_n();
    case (it.kind)
      KIND_WRITE: rtab_m[it.state_index * MaxStates + it.action_index] = it.reward;
      KIND_PLACE: agent_m = it.state_index;
      KIND_QUERY: begin
        for (int i = 0; i < n; i++)
          if (qtab_m[it.state_index * MaxStates + i] > r.best_q) begin
            r.best_q = qtab_m[it.state_index * MaxStates + i];
            r.top_action = 3'(i);
          end
      end
      default: begin
        s = int'(agent_m);
        cnt = 0;
        for (int i = 0; i < n; i++)
          if (rtab_m[s * MaxStates + i] >= 0) begin
            moves[cnt] = i;
            cnt++;
          end
        if (cnt == 0) begin
          r.no_move_error = 1'b1;
        end else begin
          a = moves[it.pick_random % cnt];
          mx = '0;
          for (int i = 0; i < n; i++)
            if (rtab_m[a * MaxStates + i] >= 0 && qtab_m[a * MaxStates + i] > mx)
              mx = qtab_m[a * MaxStates + i];
          idx = s * MaxStates + a;
          sum = (64'(unsigned'(16'(rtab_m[idx]))) << FracBits) + ((64'(gain_m) * mx) >> 8);
          if (sum > 64'(QMax)) sum = 64'(QMax);
          qtab_m[idx] = sum[QW-1:0];
          r.taken_action = 3'(a);
          r.updated_q = sum[QW-1:0];
          if (a == int'(goal_m)) begin
            r.episode_done = 1'b1;
            agent_m = 3'(it.restart_random % n);
          end else begin
            agent_m = 3'(a);
          end
        end
      end
    endcase
    return r;
  endfunction

  // driver
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_step(pending_q.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].restart_random, pending_q[0].pick_random,
                            pending_q[0].reward, pending_q[0].action_index,
                            pending_q[0].state_index};
          s_axis_tuser  <= pending_q[0].kind;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  res_t got, exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.taken_action != exp_r.taken_action) begin
            $error("taken_action exp %0d got %0d", exp_r.taken_action, got.taken_action);
            errors++;
          end
          if (got.updated_q != exp_r.updated_q) begin
            $error("updated_q exp %h got %h", exp_r.updated_q, got.updated_q);
            errors++;
          end
          if (got.episode_done != exp_r.episode_done) begin
            $error("episode_done exp %0d got %0d", exp_r.episode_done, got.episode_done);
            errors++;
          end
          if (got.top_action != exp_r.top_action) begin
            $error("top_action exp %0d got %0d", exp_r.top_action, got.top_action);
            errors++;
          end
          if (got.best_q != exp_r.best_q) begin
            $error("best_q exp %h got %h", exp_r.best_q, got.best_q);
            errors++;
          end
          if (got.no_move_error != exp_r.no_move_error) begin
            $error("no_move_error exp %0d got %0d", exp_r.no_move_error, got.no_move_error);
            errors++;
          end
        end
      end
      if (hold_rx) m_axis_tready <= 1'b0;
      else if ((cycles / 300) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (rst_ni);
    wait (pending_q.size() > 100);
    repeat (20) @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_req(kind_e k, int s, int a, int rw, int pr, int rr);
    item_t it;
    it.kind = k;
    it.state_index = 3'(s);
    it.action_index = 3'(a);
    it.reward = RW'(rw);
    it.pick_random = 16'(pr);
    it.restart_random = 16'(rr);
    pending_q.push_back(it);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_GAIN: gain_m = val;
      CFG_GOAL: goal_m = val[2:0];
      default:  used_m = val[3:0];
    endcase
  endtask

  task automatic random_phase(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k < 3)
        add_req(KIND_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                ($urandom_range(0, 3) == 0) ? -$urandom_range(1, 512) : $urandom_range(0, 511),
                $urandom, $urandom);
      else if (k < 7)
        add_req(KIND_TRAIN, $urandom, $urandom, $urandom, $urandom_range(0, 65535),
                $urandom_range(0, 65535));
      else if (k < 9)
        add_req(KIND_QUERY, $urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
      else
        add_req(KIND_PLACE, $urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  int gains [4] = '{0, 255, 128, 230};
  int goals [4] = '{0, 7, 3, 6};
  int useds [4] = '{1, 8, 0, 15};

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    gain_m = 8'd205;
    goal_m = 3'd5;
    used_m = 4'd6;
    agent_m = 3'd1;
    for (int i = 0; i < Depth; i++) begin
      qtab_m[i] = '0;
      rtab_m[i] = '1;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: no move and field extremes
    add_req(KIND_TRAIN, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    add_req(KIND_QUERY, 7, 7, 0, 0, 0);
    add_req(KIND_WRITE, 1, 5, 511, 16'hFFFF, 16'hFFFF);
    add_req(KIND_WRITE, 1, 2, 0, 0, 0);
    add_req(KIND_WRITE, 5, 1, -512, 0, 0);
    add_req(KIND_WRITE, 5, 0, 300, 0, 0);
    add_req(KIND_WRITE, 1, 7, 10, 0, 0);
    add_req(KIND_PLACE, 1, 7, -1, 0, 0);
    add_req(KIND_TRAIN, 7, 7, -1, 0, 16'hFFFF);
    add_req(KIND_TRAIN, 0, 0, 0, 1, 0);
    add_req(KIND_PLACE, 5, 0, 0, 0, 0);
    add_req(KIND_TRAIN, 0, 0, 0, 0, 0);
    add_req(KIND_QUERY, 1, 0, 0, 0, 0);
    add_req(KIND_QUERY, 5, 0, 0, 0, 0);
    add_req(KIND_WRITE, 7, 7, 5, 0, 0);
    add_req(KIND_PLACE, 7, 0, 0, 0, 0);
    add_req(KIND_TRAIN, 0, 0, 0, 0, 0);
    drain();

    // toward saturation: big reward, full gain, repeated self loop
    write_reg(CFG_GAIN, 8'd255);
    write_reg(CFG_USED, 8'd8);
    write_reg(CFG_GOAL, 8'd0);
    add_req(KIND_WRITE, 3, 3, 511, 0, 0);
    add_req(KIND_PLACE, 3, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) add_req(KIND_TRAIN, 0, 0, 0, 0, 0);
    add_req(KIND_QUERY, 3, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_GAIN, 8'(gains[p]));
      write_reg(CFG_GOAL, 8'(goals[p]));
      write_reg(CFG_USED, 8'(useds[p]));
      random_phase(330);
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
sv/qls_pkg.sv
sv/qls_front.sv
sv/qls_mod.sv
sv/qls_back.sv
sv/tabular_q_learning_step_unit.sv
dv/tb_top.sv
